// ===== src/ata_tf_pkg.sv =====
// Package for the ATA task file register block: access and result types,
// register indexes, bit positions and the fixed register values.
// No dependencies.
package ata_tf_pkg;

   typedef logic [3:0] reg_index_type;

   // Register indexes on the bus.
   localparam reg_index_type REG_DATA           = 4'd0;
   localparam reg_index_type REG_ERROR_FEATURE  = 4'd1;
   localparam reg_index_type REG_SECTOR_COUNT   = 4'd2;
   localparam reg_index_type REG_SECTOR_NUMBER  = 4'd3;
   localparam reg_index_type REG_CYLINDER_LOW   = 4'd4;
   localparam reg_index_type REG_CYLINDER_HIGH  = 4'd5;
   localparam reg_index_type REG_DRIVE_HEAD     = 4'd6;
   localparam reg_index_type REG_STATUS_COMMAND = 4'd7;
   localparam reg_index_type REG_DEVICE_CONTROL = 4'd8;

   // Supported command bytes.
   localparam logic [7:0] CMD_IDENTIFY  = 8'hEC;
   localparam logic [7:0] CMD_INIT_PARM = 8'h91;

   // Bit positions.
   localparam int DC_SRST_BIT = 2;
   localparam int DC_NIEN_BIT = 1;
   localparam int DH_DRV_BIT  = 4;

   // Status bits.
   localparam logic [7:0] ST_BSY  = 8'h80;
   localparam logic [7:0] ST_DRDY = 8'h40;
   localparam logic [7:0] ST_DSC  = 8'h10;
   localparam logic [7:0] ST_DRQ  = 8'h08;

   localparam logic [7:0] DH_KEEP_MASK = 8'hF0;
   localparam logic [7:0] ABSENT_READ  = 8'hFF;

   // Reset values.
   localparam logic [7:0] RST_ERROR          = 8'h01;
   localparam logic [7:0] RST_FEATURE        = 8'h00;
   localparam logic [7:0] RST_SECTOR_COUNT   = 8'h01;
   localparam logic [7:0] RST_SECTOR_NUMBER  = 8'h01;
   localparam logic [7:0] RST_CYLINDER       = 8'h00;
   localparam logic [7:0] RST_DRIVE_HEAD     = 8'hA0;
   localparam logic [7:0] RST_STATUS         = ST_DRDY;
   localparam logic [7:0] RST_COMMAND        = 8'h00;
   localparam logic [7:0] RST_DEVICE_CONTROL = 8'h08;

   typedef struct packed {
      logic          is_write;
      reg_index_type reg_index;
      logic [7:0]    write_data;
   } access_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       bad_access;
      logic       irq_level;
   } result_type;

endpackage

// ===== src/ata_tf_regfile.sv =====
// Task file register state and the decode of one bus access.
// Depends on ata_tf_pkg.
module ata_tf_regfile
   import ata_tf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  access_type access,
   output result_type result
);

   logic [7:0] error_ff, feature_ff, sector_count_ff, sector_number_ff;
   logic [7:0] cylinder_low_ff, cylinder_high_ff, drive_head_ff;
   logic [7:0] status_ff, command_ff, device_control_ff;
   logic       drive_present_ff, irq_pending_ff;

   logic [7:0] error_in, feature_in, sector_count_in, sector_number_in;
   logic [7:0] cylinder_low_in, cylinder_high_in, drive_head_in;
   logic [7:0] status_in, command_in, device_control_in;
   logic       drive_present_in, irq_pending_in;

   logic       srst_was;
   logic       srst_now;

   assign srst_was = device_control_ff[DC_SRST_BIT];
   assign srst_now = access.write_data[DC_SRST_BIT];

   always_comb begin
      error_in          = error_ff;
      feature_in        = feature_ff;
      sector_count_in   = sector_count_ff;
      sector_number_in  = sector_number_ff;
      cylinder_low_in   = cylinder_low_ff;
      cylinder_high_in  = cylinder_high_ff;
      drive_head_in     = drive_head_ff;
      status_in         = status_ff;
      command_in        = command_ff;
      device_control_in = device_control_ff;
      drive_present_in  = drive_present_ff;
      irq_pending_in    = irq_pending_ff;
      result            = '0;

      if (access.is_write) begin
         if (access.reg_index == REG_DRIVE_HEAD) begin
            drive_head_in    = access.write_data;
            drive_present_in = ~access.write_data[DH_DRV_BIT];
         end else if (access.reg_index == REG_DEVICE_CONTROL) begin
            if (srst_was && !srst_now) begin
               drive_head_in    = drive_head_ff & DH_KEEP_MASK;
               status_in        = ST_DRDY | ST_DSC;
               sector_count_in  = RST_SECTOR_COUNT;
               sector_number_in = RST_SECTOR_NUMBER;
               cylinder_low_in  = RST_CYLINDER;
               cylinder_high_in = RST_CYLINDER;
               error_in         = RST_ERROR;
               command_in       = RST_COMMAND;
            end else if (!srst_was && srst_now) begin
               error_in  = RST_ERROR;
               status_in = ST_BSY | ST_DSC;
            end
            device_control_in = access.write_data;
         end else if (drive_present_ff) begin
            unique case (access.reg_index)
               REG_ERROR_FEATURE:  feature_in       = access.write_data;
               REG_SECTOR_COUNT:   sector_count_in  = access.write_data;
               REG_SECTOR_NUMBER:  sector_number_in = access.write_data;
               REG_CYLINDER_LOW:   cylinder_low_in  = access.write_data;
               REG_CYLINDER_HIGH:  cylinder_high_in = access.write_data;
               REG_STATUS_COMMAND: begin
                  command_in = access.write_data;
                  priority if (access.write_data == CMD_IDENTIFY) begin
                     status_in = ST_DRDY | ST_DSC | ST_DRQ;
                  end else if (access.write_data == CMD_INIT_PARM) begin
                     status_in = ST_DRDY | ST_DSC;
                     error_in  = 8'h00;
                  end else begin
                     result.bad_access = 1'b1;
                  end
                  if (!result.bad_access && !device_control_ff[DC_NIEN_BIT]) begin
                     irq_pending_in = 1'b1;
                  end
               end
               default:            result.bad_access = 1'b1;
            endcase
         end
      end else if (!drive_present_ff) begin
         result.read_data = ABSENT_READ;
      end else begin
         unique case (access.reg_index)
            REG_ERROR_FEATURE:  result.read_data = error_ff;
            REG_SECTOR_COUNT:   result.read_data = sector_count_ff;
            REG_SECTOR_NUMBER:  result.read_data = sector_number_ff;
            REG_CYLINDER_LOW:   result.read_data = cylinder_low_ff;
            REG_CYLINDER_HIGH:  result.read_data = cylinder_high_ff;
            REG_DRIVE_HEAD:     result.read_data = drive_head_ff;
            REG_STATUS_COMMAND: begin
               result.read_data = status_ff;
               irq_pending_in   = 1'b0;
            end
            REG_DEVICE_CONTROL: result.read_data = status_ff;
            default:            result.bad_access = 1'b1;
         endcase
      end

      result.irq_level = irq_pending_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         error_ff          <= RST_ERROR;
         feature_ff        <= RST_FEATURE;
         sector_count_ff   <= RST_SECTOR_COUNT;
         sector_number_ff  <= RST_SECTOR_NUMBER;
         cylinder_low_ff   <= RST_CYLINDER;
         cylinder_high_ff  <= RST_CYLINDER;
         drive_head_ff     <= RST_DRIVE_HEAD;
         status_ff         <= RST_STATUS;
         command_ff        <= RST_COMMAND;
         device_control_ff <= RST_DEVICE_CONTROL;
         drive_present_ff  <= 1'b1;
         irq_pending_ff    <= 1'b0;
      end else if (fire) begin
         error_ff          <= error_in;
         feature_ff        <= feature_in;
         sector_count_ff   <= sector_count_in;
         sector_number_ff  <= sector_number_in;
         cylinder_low_ff   <= cylinder_low_in;
         cylinder_high_ff  <= cylinder_high_in;
         drive_head_ff     <= drive_head_in;
         status_ff         <= status_in;
         command_ff        <= command_in;
         device_control_ff <= device_control_in;
         drive_present_ff  <= drive_present_in;
         irq_pending_ff    <= irq_pending_in;
      end
   end

endmodule

// ===== src/ata_task_file_register_block_core.sv =====
// Top level of the ATA task file register block: input beat register,
// register file with access decode, and result beat register.
// Depends on ata_tf_pkg and ata_tf_regfile.
//
// Usage: each req beat is one byte-wide bus access (req_command 0 read,
// 1 write, req_reg_index 0..8, req_write_data). Every access produces
// exactly one rsp beat carrying the read byte (zero on writes), a flag for
// bad accesses (data port, index above 8, unsupported command byte) and
// the interrupt request level after the access.
// Flow: a request beat lands in the input register at its accept edge;
// the access is decoded from that register and applied to the task file
// at the edge that also registers its response beat and sets rsp_valid.
// Throughput is one access per cycle while rsp_ready stays high, set by
// the single decode pass between the two registers.
// Reset (synchronous, active high) empties both beat registers and loads
// the power-on task file values: error 0x01, sector count and number
// 0x01, drive/head 0xA0, status 0x40, device control 0x08, drive present,
// no interrupt pending.
// Stalls: while rsp_ready is low the response beat holds; the input
// register still takes one more request, then req_ready drops until the
// response beat is taken.
module ata_task_file_register_block_core
   import ata_tf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_command,
   input  logic [3:0] req_reg_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_read_data,
   output logic       rsp_bad_access,
   output logic       rsp_irq_level
);

   // Input beat register.
   logic       in_valid_ff;
   access_type access_ff;

   // Result beat register.
   logic       rsp_valid_ff;
   result_type result_ff;

   result_type result_in;
   logic       advance;

   // The access in the input register is applied when the result register
   // is empty or its beat is taken in this same cycle.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   ata_tf_regfile u_regfile (
      .clock  (clock),
      .reset  (reset),
      .fire   (advance),
      .access (access_ff),
      .result (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   // Payload needs no reset; it is only looked at while its valid is set.
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         access_ff.is_write   <= req_command;
         access_ff.reg_index  <= req_reg_index;
         access_ff.write_data <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = result_ff.read_data;
   assign rsp_bad_access = result_ff.bad_access;
   assign rsp_irq_level  = result_ff.irq_level;

   // An empty result register never holds back the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("req_ready low while the result register is empty");

   // A pending access that cannot move on stays in the input register.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff)
      else $error("pending access dropped from the input register");

   // Bad accesses always carry a zero read byte.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_access) |-> (rsp_read_data == 8'h00))
      else $error("bad access returned a nonzero byte");

   // A data port read is either flagged bad or sees an absent drive.
   assert property (@(posedge clock) disable iff (reset)
      (advance && !access_ff.is_write && access_ff.reg_index == REG_DATA)
      |=> (rsp_valid_ff && (rsp_bad_access || rsp_read_data == ABSENT_READ)))
      else $error("data port read not flagged");

endmodule

// ===== tb/sv/ata_task_file_register_block_core_tb.sv =====
// Self-checking testbench for the ATA task file register block core.
// It predicts every response beat with its own copy of the task file and
// checks it field by field. Depends on ata_tf_pkg and the core RTL.
module ata_task_file_register_block_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import ata_tf_pkg::*;

   // Bus access kinds carried on req_command.
   localparam logic ACC_READ  = 1'b0;
   localparam logic ACC_WRITE = 1'b1;

   // The index field is four bits wide, so indexes above the device
   // control register are legal on the port and must be exercised.
   localparam reg_index_type REG_INDEX_TOP = 4'hF;

   // Cycles allowed after the last response for a stray beat to show up.
   localparam int DRAIN_CYCLES = 8;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_command = ACC_READ;
   logic [3:0] req_reg_index = REG_DATA;
   logic [7:0] req_write_data = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_read_data;
   logic       rsp_bad_access;
   logic       rsp_irq_level;

   ata_task_file_register_block_core u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_reg_index  (req_reg_index),
      .req_write_data (req_write_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_data  (rsp_read_data),
      .rsp_bad_access (rsp_bad_access),
      .rsp_irq_level  (rsp_irq_level)
   );

   // A 20 ns clock period.
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Our own copy of the task file. It is advanced once for every request
   // beat at the edge where that beat is accepted.
   logic [7:0] tf_error;
   logic [7:0] tf_feature;
   logic [7:0] tf_sector_count;
   logic [7:0] tf_sector_number;
   logic [7:0] tf_cylinder_low;
   logic [7:0] tf_cylinder_high;
   logic [7:0] tf_drive_head;
   logic [7:0] tf_status;
   logic [7:0] tf_command;
   logic [7:0] tf_device_control;
   logic       tf_drive_present;
   logic       tf_irq_pending;

   // Response beats that the task file owes us, oldest first.
   result_type owed_responses[$];
   int         mismatch_count = 0;

   // Idling controls shared between the test tasks and the two sides.
   bit req_idle_en = 1'b1;
   bit rsp_idle_en = 1'b1;
   int rsp_hold_cycles = 0;

   task automatic load_power_on_values();
      tf_error          = RST_ERROR;
      tf_feature        = RST_FEATURE;
      tf_sector_count   = RST_SECTOR_COUNT;
      tf_sector_number  = RST_SECTOR_NUMBER;
      tf_cylinder_low   = RST_CYLINDER;
      tf_cylinder_high  = RST_CYLINDER;
      tf_drive_head     = RST_DRIVE_HEAD;
      tf_status         = RST_STATUS;
      tf_command        = RST_COMMAND;
      tf_device_control = RST_DEVICE_CONTROL;
      tf_drive_present  = 1'b1;
      tf_irq_pending    = 1'b0;
   endtask

   // Applies one bus access to the task file copy and returns the response
   // beat that the block must produce for it.
   function automatic result_type apply_bus_access(logic is_write, reg_index_type idx,
                                                   logic [7:0] data);
      result_type res;
      logic       srst_was;
      logic       srst_now;
      res = '0;
      if (is_write) begin
         if (idx == REG_DRIVE_HEAD) begin
            // The drive select bit decides whether anyone answers at all.
            tf_drive_head    = data;
            tf_drive_present = !data[DH_DRV_BIT];
         end else if (idx == REG_DEVICE_CONTROL) begin
            // Device control is taken even with the drive absent. Only the
            // edges of the soft reset bit matter, not its level.
            srst_was = tf_device_control[DC_SRST_BIT];
            srst_now = data[DC_SRST_BIT];
            if (srst_was && !srst_now) begin
               tf_drive_head    = tf_drive_head & DH_KEEP_MASK;
               tf_status        = ST_DRDY | ST_DSC;
               tf_sector_count  = RST_SECTOR_COUNT;
               tf_sector_number = RST_SECTOR_NUMBER;
               tf_cylinder_low  = RST_CYLINDER;
               tf_cylinder_high = RST_CYLINDER;
               tf_error         = RST_ERROR;
               tf_command       = RST_COMMAND;
            end else if (!srst_was && srst_now) begin
               tf_error  = RST_ERROR;
               tf_status = ST_BSY | ST_DSC;
            end
            tf_device_control = data;
         end else if (tf_drive_present) begin
            case (idx)
               REG_ERROR_FEATURE: tf_feature       = data;
               REG_SECTOR_COUNT:  tf_sector_count  = data;
               REG_SECTOR_NUMBER: tf_sector_number = data;
               REG_CYLINDER_LOW:  tf_cylinder_low  = data;
               REG_CYLINDER_HIGH: tf_cylinder_high = data;
               REG_STATUS_COMMAND: begin
                  // The byte always lands in the command register, but only
                  // the two supported commands touch status or interrupt.
                  tf_command = data;
                  if (data == CMD_IDENTIFY) begin
                     tf_status = ST_DRDY | ST_DSC | ST_DRQ;
                  end else if (data == CMD_INIT_PARM) begin
                     tf_status = ST_DRDY | ST_DSC;
                     tf_error  = 8'h00;
                  end else begin
                     res.bad_access = 1'b1;
                  end
                  if (!res.bad_access && !tf_device_control[DC_NIEN_BIT])
                     tf_irq_pending = 1'b1;
               end
               default: res.bad_access = 1'b1;
            endcase
         end
      end else if (!tf_drive_present) begin
         // Nobody drives the bus, so it floats high and nothing is flagged.
         res.read_data = ABSENT_READ;
      end else begin
         case (idx)
            REG_ERROR_FEATURE:  res.read_data = tf_error;
            REG_SECTOR_COUNT:   res.read_data = tf_sector_count;
            REG_SECTOR_NUMBER:  res.read_data = tf_sector_number;
            REG_CYLINDER_LOW:   res.read_data = tf_cylinder_low;
            REG_CYLINDER_HIGH:  res.read_data = tf_cylinder_high;
            REG_DRIVE_HEAD:     res.read_data = tf_drive_head;
            REG_STATUS_COMMAND: begin
               // A status read acknowledges the interrupt.
               tf_irq_pending = 1'b0;
               res.read_data  = tf_status;
            end
            REG_DEVICE_CONTROL: res.read_data = tf_status;
            default:            res.bad_access = 1'b1;
         endcase
      end
      res.irq_level = tf_irq_pending;
      return res;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      if ($urandom_range(0, 99) < 85)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offers one request beat and returns at the edge where it is accepted.
   // Inputs only change at the falling edge. When no gap is wanted, valid
   // simply stays high from the previous beat and only the payload changes.
   task automatic send_access(logic is_write, reg_index_type idx, logic [7:0] data);
      int gap;
      gap = 0;
      if (req_idle_en && $urandom_range(0, 2) == 0)
         gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid      <= 1'b1;
      req_command    <= is_write;
      req_reg_index  <= idx;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      owed_responses.push_back(apply_bus_access(is_write, idx, data));
   endtask

   // Drops valid and waits until every owed response beat has come back.
   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (owed_responses.size() != 0)
         @(posedge clock);
   endtask

   // Random traffic shaped like a driver would talk to the device: mostly
   // register reads and writes with the drive present, supported commands
   // most of the time, and a smaller share of data port, out-of-range
   // indexes, unsupported commands and deselects.
   task automatic send_random_access();
      int            pick;
      logic [7:0]    data;
      reg_index_type idx;
      pick = $urandom_range(0, 99);
      data = 8'($urandom);
      idx  = reg_index_type'($urandom_range(REG_ERROR_FEATURE, REG_CYLINDER_HIGH));
      if (pick < 10) begin
         // Keep the drive selected most of the time.
         if ($urandom_range(0, 4) != 0)
            data[DH_DRV_BIT] = 1'b0;
         send_access(ACC_WRITE, REG_DRIVE_HEAD, data);
      end else if (pick < 20) begin
         send_access(ACC_WRITE, REG_DEVICE_CONTROL, data);
      end else if (pick < 35) begin
         case ($urandom_range(0, 4))
            0, 1:    data = CMD_IDENTIFY;
            2, 3:    data = CMD_INIT_PARM;
            default: ;
         endcase
         send_access(ACC_WRITE, REG_STATUS_COMMAND, data);
      end else if (pick < 75) begin
         if ($urandom_range(0, 9) == 0)
            idx = reg_index_type'($urandom_range(REG_DATA, REG_INDEX_TOP));
         else
            idx = reg_index_type'($urandom_range(REG_ERROR_FEATURE, REG_DEVICE_CONTROL));
         send_access(ACC_READ, idx, data);
      end else begin
         if ($urandom_range(0, 9) == 0)
            idx = reg_index_type'($urandom_range(REG_DATA, REG_INDEX_TOP));
         send_access(ACC_WRITE, idx, data);
      end
   endtask

   // Reads every register from error up to status right after reset, plus
   // the data port and the highest index, which are both flagged as bad.
   task automatic test_power_on_values();
      send_access(ACC_READ, REG_ERROR_FEATURE, 8'hFF);
      send_access(ACC_READ, REG_SECTOR_COUNT, 8'h00);
      send_access(ACC_READ, REG_SECTOR_NUMBER, 8'h00);
      send_access(ACC_READ, REG_CYLINDER_LOW, 8'h00);
      send_access(ACC_READ, REG_CYLINDER_HIGH, 8'h00);
      send_access(ACC_READ, REG_DRIVE_HEAD, 8'h00);
      send_access(ACC_READ, REG_STATUS_COMMAND, 8'h00);
      send_access(ACC_READ, REG_DATA, 8'h00);
      send_access(ACC_READ, REG_INDEX_TOP, 8'hFF);
   endtask

   // Both supported commands with interrupts enabled, IDENTIFY with them
   // masked, the alternate status read that keeps the interrupt, the status
   // read that clears it, an unsupported command byte and a data port write.
   task automatic test_command_and_interrupt();
      send_access(ACC_WRITE, REG_DEVICE_CONTROL, 8'h00);
      send_access(ACC_WRITE, REG_STATUS_COMMAND, CMD_IDENTIFY);
      send_access(ACC_READ, REG_DEVICE_CONTROL, 8'h00);
      send_access(ACC_READ, REG_STATUS_COMMAND, 8'h00);
      send_access(ACC_WRITE, REG_STATUS_COMMAND, CMD_INIT_PARM);
      send_access(ACC_READ, REG_ERROR_FEATURE, 8'h00);
      send_access(ACC_WRITE, REG_STATUS_COMMAND, 8'h00);
      send_access(ACC_WRITE, REG_DEVICE_CONTROL, 8'h02);
      send_access(ACC_WRITE, REG_STATUS_COMMAND, CMD_IDENTIFY);
      send_access(ACC_WRITE, REG_DATA, 8'hFF);
   endtask

   // Soft reset rising and falling, then a deselected drive that floats
   // reads high and ignores a command, and finally selecting it again.
   task automatic test_soft_reset_and_absent_drive();
      send_access(ACC_WRITE, REG_SECTOR_COUNT, 8'hFF);
      send_access(ACC_WRITE, REG_DEVICE_CONTROL, 8'h04);
      send_access(ACC_WRITE, REG_DEVICE_CONTROL, 8'h00);
      send_access(ACC_READ, REG_SECTOR_COUNT, 8'h00);
      send_access(ACC_WRITE, REG_DRIVE_HEAD, 8'hFF);
      send_access(ACC_READ, REG_STATUS_COMMAND, 8'h00);
      send_access(ACC_WRITE, REG_STATUS_COMMAND, CMD_IDENTIFY);
      send_access(ACC_WRITE, REG_DRIVE_HEAD, 8'h00);
   endtask

   task automatic test_random_traffic(int count);
      repeat (count) send_random_access();
   endtask

   // No idling on either side, so beats move every cycle.
   task automatic test_back_to_back(int count);
      req_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      repeat (count) send_random_access();
      req_idle_en = 1'b1;
      rsp_idle_en = 1'b1;
   endtask

   // The response side holds off for a long stretch while requests keep
   // coming, so the block fills up and must stall its request side.
   task automatic test_response_backpressure(int count);
      req_idle_en     = 1'b0;
      rsp_hold_cycles = 80;
      repeat (count) send_random_access();
      req_idle_en = 1'b1;
   endtask

   // The request side goes quiet until everything has come back, then
   // traffic resumes from an empty pipeline.
   task automatic test_sender_pause(int count);
      repeat (count) send_random_access();
      wait_for_responses();
      repeat (count) send_random_access();
   endtask

   // Response side: ready changes at the falling edge. A hold request from a
   // test overrides the random stalls and is counted down here.
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            stall_left      = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else if (stall_left == 0 && rsp_idle_en && $urandom_range(0, 3) == 0) begin
            stall_left = pick_gap();
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Every accepted response beat is matched against the oldest one owed.
   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_responses.size() == 0) begin
            $error("response beat with none owed: read_data %02h", rsp_read_data);
            mismatch_count++;
         end else begin
            want = owed_responses.pop_front();
            if (rsp_read_data !== want.read_data) begin
               $error("read_data: expected %02h, actual %02h", want.read_data, rsp_read_data);
               mismatch_count++;
            end
            if (rsp_bad_access !== want.bad_access) begin
               $error("bad_access: expected %0b, actual %0b", want.bad_access,
                      rsp_bad_access);
               mismatch_count++;
            end
            if (rsp_irq_level !== want.irq_level) begin
               $error("irq_level: expected %0b, actual %0b", want.irq_level, rsp_irq_level);
               mismatch_count++;
            end
         end
      end
   end

   // Hard limit on the run in case the block stops answering.
   initial begin
      #20ms;
      $display("ata_task_file_register_block_core_tb failed");
      $finish;
   end

   initial begin
      load_power_on_values();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_values();
      test_command_and_interrupt();
      test_soft_reset_and_absent_drive();
      test_random_traffic(900);
      test_back_to_back(150);
      test_response_backpressure(60);
      test_sender_pause(100);

      // Let everything come back, then give a stray beat time to appear.
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ata_task_file_register_block_core_tb passed");
      else
         $display("ata_task_file_register_block_core_tb failed");
      $finish;
   end

endmodule
